// ===== rtl/core/bsf_pkg.sv =====
// ============================================================================
// bsf_pkg
// Shared widths, codes and record types of the blob shape filter.
// ============================================================================
`default_nettype none

package bsf_pkg;

    localparam int COORD_W    = 12;
    localparam int CNT_W      = 16;
    localparam int LABEL_W    = 16;
    localparam int PIXCNT_W   = 16;
    localparam int CNTREG_W   = 16;
    localparam int EXT_W      = 12;
    localparam int PCT_W      = 7;

    localparam int HUNDRED    = 100;
    localparam int HUND_W     = 7;

    localparam int CMPC_W     = (CNT_W > CNTREG_W) ? CNT_W : CNTREG_W;
    localparam int CMPE_W     = (COORD_W > EXT_W) ? COORD_W : EXT_W;
    localparam int N100_W     = CNT_W + HUND_W;
    localparam int WH_W       = 2 * COORD_W;
    localparam int FWH_W      = PCT_W + WH_W;
    localparam int FILL_W     = (N100_W > FWH_W) ? N100_W : FWH_W;
    localparam int ASP_W      = COORD_W + ((HUND_W > PCT_W) ? HUND_W : PCT_W);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int REGIDX_W   = 3;
    localparam logic [REGIDX_W-1:0] REG_MIN_COUNT  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_MAX_COUNT  = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_MAX_EXTENT = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_FILL_PCT   = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_ASPECT_PCT = 3'd4;

    localparam logic [CNTREG_W-1:0] RST_MIN_COUNT  = 16'd30;
    localparam logic [CNTREG_W-1:0] RST_MAX_COUNT  = 16'd125;
    localparam logic [EXT_W-1:0]    RST_MAX_EXTENT = 12'd18;
    localparam logic [PCT_W-1:0]    RST_FILL_PCT   = 7'd65;
    localparam logic [PCT_W-1:0]    RST_ASPECT_PCT = 7'd30;

    typedef enum logic [2:0] {
        RSN_KEPT,
        RSN_COUNT,
        RSN_FLAT,
        RSN_BIG,
        RSN_SPARSE,
        RSN_ELONG
    } t_reason;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [CNT_W-1:0]   count;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_region;

    typedef struct packed {
        logic [CNTREG_W-1:0] min_count;
        logic [CNTREG_W-1:0] max_count;
        logic [EXT_W-1:0]    max_extent;
        logic [PCT_W-1:0]    fill_pct;
        logic [PCT_W-1:0]    aspect_pct;
    } t_cfg;

    typedef struct packed {
        logic [LABEL_W-1:0]  label;
        logic                remove;
        t_reason             reason;
        logic [PIXCNT_W-1:0] count;
        logic [COORD_W-1:0]  width;
        logic [COORD_W-1:0]  height;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/bsf_front.sv =====
// ============================================================================
// bsf_front
// Pixel accumulator: tracks count and bounding box, emits one region record.
// ============================================================================
`default_nettype none

module bsf_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [bsf_pkg::COORD_W-1:0] i_x,
    input  wire logic [bsf_pkg::COORD_W-1:0] i_y,
    input  wire logic [bsf_pkg::LABEL_W-1:0] i_label,
    input  wire logic                        i_last,
    input  wire logic                        i_full,
    output logic                             o_push,
    output bsf_pkg::t_region                 o_rec
);

    logic [bsf_pkg::COORD_W-1:0] r_min_col, r_max_col, r_min_row, r_max_row;
    logic [bsf_pkg::COORD_W-1:0] n_min_col, n_max_col, n_min_row, n_max_row;
    logic [bsf_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && i_last;

    always_comb begin
        n_min_col = (i_x < r_min_col) ? i_x : r_min_col;
        n_max_col = (i_x > r_max_col) ? i_x : r_max_col;
        n_min_row = (i_y < r_min_row) ? i_y : r_min_row;
        n_max_row = (i_y > r_max_row) ? i_y : r_max_row;
        n_count   = (r_count == '1) ? r_count : r_count + bsf_pkg::CNT_W'(1);
        o_rec.label  = i_label;
        o_rec.count  = n_count;
        o_rec.width  = n_max_col - n_min_col;
        o_rec.height = n_max_row - n_min_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
            r_count   <= '0;
        end else if (accept) begin
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            r_count   <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bsf_queue.sv =====
// ============================================================================
// bsf_queue
// Short record queue between the pixel accumulator and the judge.
// ============================================================================
`default_nettype none

module bsf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bsf_pkg::t_region i_rec,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output bsf_pkg::t_region      o_rec
);

    bsf_pkg::t_region               r_mem [bsf_pkg::QUEUE_DEPTH];
    logic [bsf_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [bsf_pkg::QCNT_W-1:0]     r_fill;
    logic                           do_push, do_pop;

    assign o_full  = (r_fill == bsf_pkg::QCNT_W'(bsf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + bsf_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + bsf_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + bsf_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - bsf_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bsf_back.sv =====
// ============================================================================
// bsf_back
// Shape judge: cross-multiplies ratios over two stages and registers the result.
// ============================================================================
`default_nettype none

module bsf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bsf_pkg::t_cfg    i_cfg,
    input  wire logic             i_q_valid,
    input  wire bsf_pkg::t_region i_q_rec,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output bsf_pkg::t_result      o_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_JUDGE
    } t_state;

    t_state                      r_state;
    bsf_pkg::t_region            r_rec;
    logic [bsf_pkg::WH_W-1:0]    r_wh;
    logic [bsf_pkg::N100_W-1:0]  r_n100;
    logic [bsf_pkg::ASP_W-1:0]   r_w100, r_h100, r_aw, r_ah;
    logic [bsf_pkg::FWH_W-1:0]   r_fwh;
    logic                        r_out_valid;
    bsf_pkg::t_result            r_out;
    bsf_pkg::t_reason            reason;
    logic                        out_free;
    logic                        cnt_fail, flat_fail, big_fail, sparse_fail, elong_fail;

    assign o_pop       = (r_state == ST_IDLE) && i_q_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        cnt_fail = (bsf_pkg::CMPC_W'(r_rec.count) <= bsf_pkg::CMPC_W'(i_cfg.min_count))
                || (bsf_pkg::CMPC_W'(r_rec.count) >= bsf_pkg::CMPC_W'(i_cfg.max_count));
        flat_fail = (r_rec.width == '0) || (r_rec.height == '0);
        big_fail  = (bsf_pkg::CMPE_W'(r_rec.width) > bsf_pkg::CMPE_W'(i_cfg.max_extent))
                 || (bsf_pkg::CMPE_W'(r_rec.height) > bsf_pkg::CMPE_W'(i_cfg.max_extent));
        sparse_fail = bsf_pkg::FILL_W'(r_n100) < bsf_pkg::FILL_W'(r_fwh);
        elong_fail  = (r_w100 < r_ah) || (r_h100 < r_aw);
        if (cnt_fail) begin
            reason = bsf_pkg::RSN_COUNT;
        end else if (flat_fail) begin
            reason = bsf_pkg::RSN_FLAT;
        end else if (big_fail) begin
            reason = bsf_pkg::RSN_BIG;
        end else if (sparse_fail) begin
            reason = bsf_pkg::RSN_SPARSE;
        end else if (elong_fail) begin
            reason = bsf_pkg::RSN_ELONG;
        end else begin
            reason = bsf_pkg::RSN_KEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_JUDGE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_rec   <= i_q_rec;
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_wh   <= bsf_pkg::WH_W'(r_rec.width) * bsf_pkg::WH_W'(r_rec.height);
                    r_n100 <= bsf_pkg::N100_W'(r_rec.count) * bsf_pkg::N100_W'(bsf_pkg::HUNDRED);
                    r_w100 <= bsf_pkg::ASP_W'(r_rec.width) * bsf_pkg::ASP_W'(bsf_pkg::HUNDRED);
                    r_h100 <= bsf_pkg::ASP_W'(r_rec.height) * bsf_pkg::ASP_W'(bsf_pkg::HUNDRED);
                    r_aw   <= bsf_pkg::ASP_W'(r_rec.width) * bsf_pkg::ASP_W'(i_cfg.aspect_pct);
                    r_ah   <= bsf_pkg::ASP_W'(r_rec.height) * bsf_pkg::ASP_W'(i_cfg.aspect_pct);
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_fwh   <= bsf_pkg::FWH_W'(i_cfg.fill_pct) * bsf_pkg::FWH_W'(r_wh);
                    r_state <= ST_JUDGE;
                end
                ST_JUDGE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out.label  <= r_rec.label;
                        r_out.remove <= (reason != bsf_pkg::RSN_KEPT);
                        r_out.reason <= reason;
                        r_out.count  <= bsf_pkg::PIXCNT_W'(r_rec.count);
                        r_out.width  <= r_rec.width;
                        r_out.height <= r_rec.height;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_remove_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.remove == (r_out.reason != bsf_pkg::RSN_KEPT)))
        else $error("remove flag disagrees with reason");

    a_reason_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.reason <= bsf_pkg::RSN_ELONG))
        else $error("reason code out of range");

    a_result_from_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_JUDGE))
        else $error("result loaded outside judge step");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_MUL1))
        else $error("popped record not taken into the multiply step");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/blob_shape_filter_core.sv =====
// ============================================================================
// blob_shape_filter_core
// Shape filter for labelled pixel regions with APB register access.
// ============================================================================
// Usage:
//   s_axis carries one region pixel per item: tdata holds pixel_x, pixel_y and
//   region_label; tlast marks the last pixel of the region. Pixels are taken
//   one per cycle while the record queue has room.
//   m_axis carries one result per region: label, remove flag, reason code,
//   saturated pixel count and bounding box width and height.
//   A finished record passes the queue, fetch, product stage, fill product
//   stage and decision, whose result is registered. Throughput: pixels at 1 per
//   cycle while the queue has room; the judge finishes each record before it
//   takes the next, and a 4-deep queue absorbs bursts of short regions.
//   When m_axis stalls the finished result holds in its output register, the
//   judge waits on the next record and the queue fills; s_axis_tready drops
//   only when the queue is full. Reset clears the box and count, empties the
//   queue and loads the register defaults (30, 125, 18, 65, 30). The user must
//   write registers over APB only while idle; the block does not enforce it.
// ============================================================================
`default_nettype none

module blob_shape_filter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [11:0] pixel_x, [23:12] pixel_y, [39:24] region_label
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] out_label, [16] remove, [19:17] reason, [35:20] pixel_count,
    // [47:36] box_width, [59:48] box_height, [63:60] zero
    output logic [63:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int APB_DW  = 32;
    localparam int OUT_PAD = 64 - (bsf_pkg::LABEL_W + 1 + 3 + bsf_pkg::PIXCNT_W
                                   + 2 * bsf_pkg::COORD_W);

    bsf_pkg::t_cfg                   r_cfg;
    logic [bsf_pkg::REGIDX_W-1:0]    reg_idx;
    logic                            cfg_wr;
    logic                            q_full, q_push, q_valid, q_pop;
    bsf_pkg::t_region                front_rec, q_rec;
    bsf_pkg::t_result                result;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_count  <= bsf_pkg::RST_MIN_COUNT;
            r_cfg.max_count  <= bsf_pkg::RST_MAX_COUNT;
            r_cfg.max_extent <= bsf_pkg::RST_MAX_EXTENT;
            r_cfg.fill_pct   <= bsf_pkg::RST_FILL_PCT;
            r_cfg.aspect_pct <= bsf_pkg::RST_ASPECT_PCT;
        end else if (cfg_wr) begin
            case (reg_idx)
                bsf_pkg::REG_MIN_COUNT:  r_cfg.min_count  <= pwdata[bsf_pkg::CNTREG_W-1:0];
                bsf_pkg::REG_MAX_COUNT:  r_cfg.max_count  <= pwdata[bsf_pkg::CNTREG_W-1:0];
                bsf_pkg::REG_MAX_EXTENT: r_cfg.max_extent <= pwdata[bsf_pkg::EXT_W-1:0];
                bsf_pkg::REG_FILL_PCT:   r_cfg.fill_pct   <= pwdata[bsf_pkg::PCT_W-1:0];
                bsf_pkg::REG_ASPECT_PCT: r_cfg.aspect_pct <= pwdata[bsf_pkg::PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bsf_pkg::REG_MIN_COUNT:  prdata = APB_DW'(r_cfg.min_count);
            bsf_pkg::REG_MAX_COUNT:  prdata = APB_DW'(r_cfg.max_count);
            bsf_pkg::REG_MAX_EXTENT: prdata = APB_DW'(r_cfg.max_extent);
            bsf_pkg::REG_FILL_PCT:   prdata = APB_DW'(r_cfg.fill_pct);
            bsf_pkg::REG_ASPECT_PCT: prdata = APB_DW'(r_cfg.aspect_pct);
            default:                 prdata = '0;
        endcase
    end

    bsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[11:0]),
        .i_y     (s_axis_tdata[23:12]),
        .i_label (s_axis_tdata[39:24]),
        .i_last  (s_axis_tlast),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_rec   (front_rec)
    );

    bsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    bsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_rec     (q_rec),
        .o_pop       (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (result)
    );

    assign m_axis_tdata = {
        {OUT_PAD{1'b0}},
        result.height,
        result.width,
        result.count,
        result.reason,
        result.remove,
        result.label
    };

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for blob_shape_filter_core. Streams labelled region
// pixels with random gaps and output stalls, programs the shape limits over
// APB between phases, predicts each region's decision and checks every
// result field in order.
// ============================================================================

module tb;
    import bsf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 120;
    localparam int PHASE_COUNT   = 8;
    localparam logic [REGIDX_W-1:0] REG_UNUSED = 3'd5;
    localparam logic [COORD_W-1:0]  COORD_TOP  = '1;

    class region_ledger;
        logic [CNTREG_W-1:0] min_count;
        logic [CNTREG_W-1:0] max_count;
        logic [EXT_W-1:0]    max_extent;
        logic [PCT_W-1:0]    fill_pct;
        logic [PCT_W-1:0]    aspect_pct;
        logic [COORD_W-1:0]  lo_x, hi_x, lo_y, hi_y;
        logic [CNT_W-1:0]    tally;
        t_result             due_q[$];
        int                  n_pixels;
        int                  n_results;
        int                  n_errors;

        function new();
            min_count  = RST_MIN_COUNT;
            max_count  = RST_MAX_COUNT;
            max_extent = RST_MAX_EXTENT;
            fill_pct   = RST_FILL_PCT;
            aspect_pct = RST_ASPECT_PCT;
            n_pixels   = 0;
            n_results  = 0;
            n_errors   = 0;
            clear_box();
        endfunction

        function void clear_box();
            lo_x  = '1;
            hi_x  = '0;
            lo_y  = '1;
            hi_y  = '0;
            tally = '0;
        endfunction

        function void set_reg(logic [REGIDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                REG_MIN_COUNT:  min_count  = v[CNTREG_W-1:0];
                REG_MAX_COUNT:  max_count  = v[CNTREG_W-1:0];
                REG_MAX_EXTENT: max_extent = v[EXT_W-1:0];
                REG_FILL_PCT:   fill_pct   = v[PCT_W-1:0];
                REG_ASPECT_PCT: aspect_pct = v[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_reason judge(logic [CNT_W-1:0] n, logic [COORD_W-1:0] w,
                                logic [COORD_W-1:0] h);
            longint unsigned n64, w64, h64, f64, a64;
            n64 = n;
            w64 = w;
            h64 = h;
            f64 = fill_pct;
            a64 = aspect_pct;
            if (n <= min_count || n >= max_count) return RSN_COUNT;
            if (w == 0 || h == 0) return RSN_FLAT;
            if (w > max_extent || h > max_extent) return RSN_BIG;
            if (n64 * HUNDRED < f64 * w64 * h64) return RSN_SPARSE;
            if (w64 * HUNDRED < a64 * h64 || h64 * HUNDRED < a64 * w64) return RSN_ELONG;
            return RSN_KEPT;
        endfunction

        function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic [LABEL_W-1:0] label, logic last);
            t_result            e;
            t_reason            r;
            logic [COORD_W-1:0] w, h;
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
            if (tally != '1) tally++;
            n_pixels++;
            if (last) begin
                w        = hi_x - lo_x;
                h        = hi_y - lo_y;
                r        = judge(tally, w, h);
                e.label  = label;
                e.remove = (r != RSN_KEPT);
                e.reason = r;
                e.count  = tally;
                e.width  = w;
                e.height = h;
                due_q.push_back(e);
                clear_box();
            end
        endfunction

        function void same(string f, logic [31:0] expv, logic [31:0] actv);
            if (actv !== expv) begin
                $display("%0t: %s mismatch on result %0d, expected %0h, actual %0h",
                         $time, f, n_results, expv, actv);
                n_errors++;
            end
        endfunction

        function void check_result(logic [63:0] d);
            t_result e;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, d);
                n_errors++;
                return;
            end
            e = due_q.pop_front();
            same("label", 32'(e.label), 32'(d[15:0]));
            same("remove", 32'(e.remove), 32'(d[16]));
            same("reason", 32'(e.reason), 32'(d[19:17]));
            same("count", 32'(e.count), 32'(d[35:20]));
            same("width", 32'(e.width), 32'(d[47:36]));
            same("height", 32'(e.height), 32'(d[59:48]));
            same("pad", 32'(0), 32'(d[63:60]));
            n_results++;
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    region_ledger ledger = new();
    bit           src_idle  = 1'b0;
    bit           sink_idle = 1'b0;
    int           cycles    = 0;
    int           settings_used = 0;

    blob_shape_filter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [REGIDX_W-1:0] idx, logic [31:0] val);
        logic [31:0] word;
        int          w;
        case (idx)
            REG_MIN_COUNT, REG_MAX_COUNT: w = CNTREG_W;
            REG_MAX_EXTENT:               w = EXT_W;
            default:                      w = PCT_W;
        endcase
        // junk above the register width must be dropped
        word = ($urandom << w) | val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        ledger.set_reg(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] minc, logic [31:0] maxc, logic [31:0] ext,
                             logic [31:0] fill, logic [31:0] asp);
        write_reg(REG_MIN_COUNT, minc);
        write_reg(REG_MAX_COUNT, maxc);
        write_reg(REG_MAX_EXTENT, ext);
        write_reg(REG_FILL_PCT, fill);
        write_reg(REG_ASPECT_PCT, asp);
        write_reg(REGIDX_W'(32'(REG_UNUSED) + $urandom_range(0, 2)), $urandom_range(0, 127));
        settings_used++;
    endtask

    task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [LABEL_W-1:0] label, logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {label, y, x};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ledger.note_pixel(x, y, label, last);
    endtask

    task automatic send_region(int n, int sx, int sy);
        logic [COORD_W-1:0] bx, by;
        logic [LABEL_W-1:0] label;
        bit                 relabel;
        bx      = COORD_W'($urandom_range(0, int'(COORD_TOP) - sx));
        by      = COORD_W'($urandom_range(0, int'(COORD_TOP) - sy));
        label   = LABEL_W'($urandom);
        relabel = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            if (relabel && $urandom_range(0, 1) == 1) label = LABEL_W'($urandom);
            send_pixel(COORD_W'(32'(bx) + $urandom_range(0, sx)),
                       COORD_W'(32'(by) + $urandom_range(0, sy)), label,
                       i == n - 1);
        end
    endtask

    task automatic random_regions(int budget);
        int sent, n, sx, sy, pick;
        sent = 0;
        while (sent < budget) begin
            src_idle = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 14) n = $urandom_range(1, 8);
            else if (pick < 19) n = $urandom_range(9, 40);
            else n = $urandom_range(120, 135);
            sx = $urandom_range(1, 20);
            sy = $urandom_range(1, 20);
            pick = $urandom_range(0, 9);
            if (pick == 0) sx = 0;
            else if (pick == 1) sy = 0;
            else if (pick == 2) begin
                sx = int'(COORD_TOP);
                sy = int'(COORD_TOP);
            end
            send_region(n, sx, sy);
            sent += n;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int stall;
        int streak;
        streak = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (streak == 0) begin
                sink_idle = ($urandom_range(0, 2) != 0);
                streak    = $urandom_range(4, 12);
            end
            streak--;
            stall = sink_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            ledger.check_result(m_axis_tdata);
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits, single pixels at the coordinate and label extremes
        send_pixel(0, 0, 0, 1'b1);
        send_pixel(COORD_TOP, COORD_TOP, '1, 1'b1);
        drain();

        // tight limits so tiny regions reach every decision
        configure(1, 20, 8, 50, 50);
        src_idle = 1'b1;
        send_pixel(0, 5, 3, 1'b0);
        send_pixel(3, 5, 3, 1'b0);
        send_pixel(7, 5, 3, 1'b1);
        send_pixel(100, 200, 4, 1'b0);
        send_pixel(109, 201, 4, 1'b0);
        send_pixel(101, 200, 4, 1'b1);
        send_pixel(0, 0, 5, 1'b0);
        send_pixel(4, 4, 5, 1'b1);
        send_pixel(10, 10, 6, 1'b0);
        send_pixel(14, 11, 6, 1'b0);
        send_pixel(12, 10, 6, 1'b1);
        send_pixel(4094, 4094, 7, 1'b0);
        send_pixel(COORD_TOP, COORD_TOP, 9, 1'b1);
        send_pixel(2048, 2048, 16'h8000, 1'b1);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: configure(32'(RST_MIN_COUNT), 32'(RST_MAX_COUNT), 32'(RST_MAX_EXTENT),
                             32'(RST_FILL_PCT), 32'(RST_ASPECT_PCT));
                1: configure(0, 32'hFFFF, 32'hFFF, 0, 0);
                2: configure(32'hFFFF, 0, 0, 100, 100);
                3: configure(0, 32'hFFFF, 32'hFFF, 127, 127);
                4: configure(0, 200, 30, 100, 100);
                default: configure($urandom_range(0, 10), $urandom_range(20, 150),
                                   $urandom_range(3, 40), $urandom_range(0, 100),
                                   $urandom_range(0, 100));
            endcase
            random_regions(PHASE_ITEMS);
            drain();
        end

        $display("Streamed %0d pixels under %0d limit settings, %0d region decisions checked",
                 ledger.n_pixels, settings_used, ledger.n_results);
        $display("Field errors seen: %0d", ledger.n_errors);
        if (ledger.n_errors == 0 && ledger.due_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
